// ===== rtl/gma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gram matrix accumulator package
// Shared widths, saturation limits and the packed upper-triangle address map.
// ----------------------------------------------------------------------------
package gma_pkg;

  localparam int VECTOR_LENGTH = 8;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = 48;
  localparam int IDX_W    = 3;
  localparam int DIMS_W   = 4;
  localparam int SLOT_W   = 6;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(8);

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Slot of element pair (hi, lo) with lo <= hi in the packed upper triangle.
  function automatic logic [SLOT_W-1:0] tri_slot(input logic [IDX_W-1:0] hi,
                                                  input logic [IDX_W-1:0] lo);
    logic [2*IDX_W:0]   hi_ext;
    logic [2*IDX_W:0]   tri_num;
    hi_ext  = (2*IDX_W+1)'(hi);
    tri_num = hi_ext * (hi_ext + (2*IDX_W+1)'(1));
    return SLOT_W'(tri_num[2*IDX_W:1]) + SLOT_W'(lo);
  endfunction

endpackage

// ===== rtl/gram_matrix_accumulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gram matrix accumulator
// Builds X-transpose-X over probe vectors in a packed upper-triangle RAM and
// streams the mirrored matrix out in row-major order on end of set.
// ----------------------------------------------------------------------------
//  Channel   Ports                              Handshake
//  input     sample, end_of_set                 start & !busy
//  result    entry, row, col, last              strobe, one cycle each
//  config    dims_in_use                        cfg_valid & cfg_ready
//
//  An element at position k of its vector keeps busy high through a
//  read-modify-write beat for each term 0..k through the shared multiplier
//  and then a write drain. With end_of_set, d*d entries follow at one
//  per cycle, then a flush state, where d is the effective dimension.
//  Reset clears the accumulator valid bits, so no clearing pass is needed;
//  the results cannot be stalled and the config port is always ready.
// ----------------------------------------------------------------------------
module gram_matrix_accumulator_top #(
  parameter int VECTOR_LENGTH = gma_pkg::VECTOR_LENGTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [gma_pkg::SAMPLE_W-1:0] sample,
  input  logic                                end_of_set,
  output logic                                strobe,
  output logic signed [gma_pkg::ACC_W-1:0]    entry,
  output logic [gma_pkg::IDX_W-1:0]           row,
  output logic [gma_pkg::IDX_W-1:0]           col,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gma_pkg::DIMS_W-1:0]          dims_in_use
);

  localparam int TRI_DEPTH = VECTOR_LENGTH * (VECTOR_LENGTH + 1) / 2;
  localparam int TRI_AW    = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
  localparam int BUF_AW    = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int IW        = gma_pkg::IDX_W;
  localparam int DW        = gma_pkg::DIMS_W;

  typedef enum logic [2:0] {S_IDLE, S_ACCUM, S_DRAIN, S_EMIT, S_FLUSH} state_t;

  state_t                        state;
  logic [DW-1:0]                 dims_reg;
  logic [DW-1:0]                 eff_dims;
  logic [IW-1:0]                 elem_idx;
  logic [IW-1:0]                 cur_idx;
  logic [IW-1:0]                 term;
  logic [IW-1:0]                 row_cnt;
  logic [IW-1:0]                 col_cnt;
  logic signed [gma_pkg::SAMPLE_W-1:0] x_reg;
  logic signed [gma_pkg::SAMPLE_W-1:0] vbuf [VECTOR_LENGTH];
  logic                          end_flag;
  logic [TRI_DEPTH-1:0]          acc_valid;
  logic                          rd_valid;
  logic                          out_pend;
  logic [IW-1:0]                 row_q;
  logic [IW-1:0]                 col_q;
  logic                          last_q;

  logic                          accept;
  logic [IW-1:0]                 start_idx;
  logic [DW-1:0]                 idx_inc;
  logic [IW-1:0]                 idx_next;
  logic [IW-1:0]                 slot_hi;
  logic [IW-1:0]                 slot_lo;
  logic [TRI_AW-1:0]             raddr;
  logic [gma_pkg::SLOT_W-1:0]    slot;
  logic                          issue;
  logic [gma_pkg::ACC_W-1:0]     rdata;
  logic [gma_pkg::ACC_W-1:0]     acc_old;
  logic                          wr_en;
  logic [TRI_AW-1:0]             wr_addr;
  logic [gma_pkg::ACC_W-1:0]     wr_data;
  logic                          emit_end;
  logic                          col_end;

  // Out-of-range dimension settings are clamped into 1..VECTOR_LENGTH.
  always_comb begin
    if (dims_reg == '0) begin
      eff_dims = DW'(1);
    end else if (dims_reg > DW'(VECTOR_LENGTH)) begin
      eff_dims = DW'(VECTOR_LENGTH);
    end else begin
      eff_dims = dims_reg;
    end
  end

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // A shrunk dimension setting restarts the vector before the element lands.
  assign start_idx = ({1'b0, elem_idx} >= eff_dims) ? '0 : elem_idx;
  assign idx_inc   = {1'b0, start_idx} + DW'(1);
  assign idx_next  = (idx_inc >= eff_dims) ? '0 : idx_inc[IW-1:0];

  assign col_end  = ({1'b0, col_cnt} == eff_dims - DW'(1));
  assign emit_end = col_end && ({1'b0, row_cnt} == eff_dims - DW'(1));

  always_comb begin
    unique case (state)
      S_ACCUM: begin
        slot_hi = cur_idx;
        slot_lo = term;
      end
      S_EMIT: begin
        slot_hi = (row_cnt > col_cnt) ? row_cnt : col_cnt;
        slot_lo = (row_cnt > col_cnt) ? col_cnt : row_cnt;
      end
      default: begin
        slot_hi = '0;
        slot_lo = '0;
      end
    endcase
  end

  assign slot    = gma_pkg::tri_slot(slot_hi, slot_lo);
  assign raddr   = slot[TRI_AW-1:0];
  assign issue   = (state == S_ACCUM);
  assign acc_old = rd_valid ? rdata : '0;

  gma_ram #(
    .WIDTH (gma_pkg::ACC_W),
    .DEPTH (TRI_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  gma_mac #(
    .AW (TRI_AW)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_addr (raddr),
    .op_a       (vbuf[term[BUF_AW-1:0]]),
    .op_b       (x_reg),
    .acc_old    (acc_old),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dims_reg  <= gma_pkg::DIMS_RESET;
      elem_idx  <= '0;
      acc_valid <= '0;
      rd_valid  <= 1'b0;
      out_pend  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dims_reg <= dims_in_use;
      end
      rd_valid <= acc_valid[raddr];
      if (wr_en) begin
        acc_valid[wr_addr] <= 1'b1;
      end
      out_pend <= (state == S_EMIT);
      row_q    <= row_cnt;
      col_q    <= col_cnt;
      last_q   <= emit_end;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            vbuf[start_idx[BUF_AW-1:0]] <= sample;
            x_reg    <= sample;
            cur_idx  <= start_idx;
            term     <= '0;
            end_flag <= end_of_set;
            elem_idx <= idx_next;
            state    <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          if (term == cur_idx) begin
            state <= S_DRAIN;
          end else begin
            term <= term + IW'(1);
          end
        end
        S_DRAIN: begin
          row_cnt <= '0;
          col_cnt <= '0;
          state   <= end_flag ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (col_end) begin
            col_cnt <= '0;
            row_cnt <= row_cnt + IW'(1);
          end else begin
            col_cnt <= col_cnt + IW'(1);
          end
          if (emit_end) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          acc_valid <= '0;
          elem_idx  <= '0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign strobe = out_pend;
  assign entry  = acc_old;
  assign row    = row_q;
  assign col    = col_q;
  assign last   = last_q;

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == S_EMIT)
    else $error("result strobe without a preceding matrix read");

  a_accept_starts_accum: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_ACCUM)
    else $error("accepted element did not start accumulation");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT || state == S_IDLE) |-> !wr_en)
    else $error("accumulator write outside the accumulate phase");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe && state == S_IDLE)
    else $error("results continued after the final entry");

endmodule

// ===== rtl/gma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 36,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gma_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply and saturating accumulate
// Registers the product alongside the RAM read, then adds and writes back.
// ----------------------------------------------------------------------------
module gma_mac #(
  parameter int AW = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue,
  input  logic [AW-1:0]                       issue_addr,
  input  logic signed [gma_pkg::SAMPLE_W-1:0] op_a,
  input  logic signed [gma_pkg::SAMPLE_W-1:0] op_b,
  input  logic [gma_pkg::ACC_W-1:0]           acc_old,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic [gma_pkg::ACC_W-1:0]           wr_data
);

  logic signed [gma_pkg::PROD_W-1:0] prod;
  logic [AW-1:0]                     addr_q;
  logic                              vld_q;
  logic signed [gma_pkg::ACC_W:0]    sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= issue;
    end
    prod   <= op_a * op_b;
    addr_q <= issue_addr;
  end

  // One guard bit is enough: the product is far narrower than the accumulator.
  assign sum = $signed({acc_old[gma_pkg::ACC_W-1], acc_old})
             + (gma_pkg::ACC_W+1)'(prod);

  always_comb begin
    if (sum[gma_pkg::ACC_W] != sum[gma_pkg::ACC_W-1]) begin
      wr_data = sum[gma_pkg::ACC_W] ? gma_pkg::ACC_MIN : gma_pkg::ACC_MAX;
    end else begin
      wr_data = sum[gma_pkg::ACC_W-1:0];
    end
  end

  assign wr_en   = vld_q;
  assign wr_addr = addr_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gram matrix accumulator testbench
// Sends probe vector samples through the command port and keeps a running
// model of the packed upper-triangle sums. Each matrix entry streamed out on
// end of set is checked against the model. The run covers directed corner
// cases and random phases with varied sender gaps and dimension settings.
// ----------------------------------------------------------------------------
module testbench;
  import gma_pkg::*;

  localparam int     SETTLE_CYCLES = 80;
  localparam int     MAX_PRINTS    = 40;
  localparam longint ACC_HI        = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO        = -ACC_HI - 1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_set;
  } sample_beat_t;

  typedef struct {
    logic signed [ACC_W-1:0] entry;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } matrix_entry_t;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       start       = 1'b0;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] sample      = '0;
  logic                       end_of_set  = 1'b0;
  logic                       strobe;
  logic signed [ACC_W-1:0]    entry;
  logic [IDX_W-1:0]           row;
  logic [IDX_W-1:0]           col;
  logic                       last;
  logic                       cfg_valid   = 1'b0;
  logic                       cfg_ready;
  logic [DIMS_W-1:0]          dims_in_use = DIMS_RESET;

  logic                       beat_taken  = 1'b0;
  int                         sender_idle_pct = 0;

  sample_beat_t  sample_backlog[$];
  matrix_entry_t gram_expected[$];

  // Running copy of the block's state.
  longint                     acc_model[36];
  logic signed [SAMPLE_W-1:0] vec_model[VECTOR_LENGTH];
  int                         elem_pos;
  int                         dims_model;

  int mismatches     = 0;
  int samples_taken  = 0;
  int entries_seen   = 0;
  int dims_writes    = 0;

  gram_matrix_accumulator_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample      (sample),
    .end_of_set  (end_of_set),
    .strobe      (strobe),
    .entry       (entry),
    .row         (row),
    .col         (col),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .dims_in_use (dims_in_use)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int active_dims(int v);
    return (v == 0) ? 1 : (v > VECTOR_LENGTH) ? VECTOR_LENGTH : v;
  endfunction

  // Folds one sample into the triangle sums and, on end of set, queues the
  // whole mirrored matrix in row-major order before clearing.
  function automatic void gram_update(logic signed [SAMPLE_W-1:0] x, logic eos);
    int            d;
    int            j;
    int            r;
    int            c;
    int            slot;
    longint        sum;
    matrix_entry_t m;
    d = active_dims(dims_model);
    if (elem_pos >= d) elem_pos = 0;
    vec_model[elem_pos] = x;
    for (j = 0; j <= elem_pos; j++) begin
      slot = elem_pos * (elem_pos + 1) / 2 + j;
      sum  = acc_model[slot] + longint'(vec_model[j]) * longint'(x);
      acc_model[slot] = (sum > ACC_HI) ? ACC_HI : (sum < ACC_LO) ? ACC_LO : sum;
    end
    elem_pos++;
    if (elem_pos >= d) elem_pos = 0;
    if (eos) begin
      for (r = 0; r < d; r++) begin
        for (c = 0; c < d; c++) begin
          slot    = (r > c) ? r * (r + 1) / 2 + c : c * (c + 1) / 2 + r;
          m.entry = ACC_W'(acc_model[slot]);
          m.row   = IDX_W'(r);
          m.col   = IDX_W'(c);
          m.last  = (r == d - 1) && (c == d - 1);
          gram_expected.push_back(m);
        end
      end
      foreach (acc_model[i]) acc_model[i] = 0;
      elem_pos = 0;
    end
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Sender: a new beat goes out only once the previous one has been taken.
  always @(negedge clk) begin
    sample_beat_t b;
    if (!rst && (!start || beat_taken)) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        b = sample_backlog.pop_front();
        start      <= 1'b1;
        sample     <= b.sample;
        end_of_set <= b.end_of_set;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    matrix_entry_t want;
    beat_taken <= !rst && start && !busy;
    if (!rst) begin
      if (start && !busy) begin
        gram_update(sample, end_of_set);
        samples_taken++;
      end
      if (strobe) begin
        if (gram_expected.size() == 0) begin
          flag_mismatch($sformatf("entry (%0d,%0d) with none expected", row, col));
        end else begin
          want = gram_expected.pop_front();
          if (entry !== want.entry)
            flag_mismatch($sformatf("entry (%0d,%0d) value %0d, expected %0d",
                                    want.row, want.col, entry, want.entry));
          if (row !== want.row)
            flag_mismatch($sformatf("row %0d, expected %0d", row, want.row));
          if (col !== want.col)
            flag_mismatch($sformatf("col %0d, expected %0d", col, want.col));
          if (last !== want.last)
            flag_mismatch($sformatf("last %0b at (%0d,%0d), expected %0b",
                                    last, want.row, want.col, want.last));
          entries_seen++;
        end
      end
    end
  end

  task automatic queue_sample(logic signed [SAMPLE_W-1:0] s, logic eos);
    sample_beat_t b;
    b.sample     = s;
    b.end_of_set = eos;
    sample_backlog.push_back(b);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'($urandom_range(512)) - SAMPLE_W'(256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Waits until every beat is taken and every entry has arrived, then lets
  // a sample without end of set finish its work before anything else moves.
  task automatic settle();
    do @(posedge clk);
    while (sample_backlog.size() != 0 || start || busy || gram_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(logic [DIMS_W-1:0] v);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    dims_in_use <= v;
    do @(posedge clk);
    while (!cfg_ready);
    dims_model = v;
    dims_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int               d_eff;
    int               n;
    int               nvec;
    int               len;
    int               v;
    int               e;
    int               waited;
    logic [DIMS_W-1:0] dv;
    foreach (acc_model[i]) acc_model[i] = 0;
    foreach (vec_model[i]) vec_model[i] = '0;
    elem_pos   = 0;
    dims_model = DIMS_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full vector at the reset dimension, field extremes and unit values.
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh0000, 1'b0);
    queue_sample(16'sh0001, 1'b0);
    queue_sample(16'shFFFF, 1'b0);
    queue_sample(16'sh0100, 1'b0);
    queue_sample(16'shFF00, 1'b0);
    queue_sample(16'sh5A5A, 1'b1);
    settle();

    write_dims(4'd1);
    queue_sample(16'sh8000, 1'b1);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh7FFF, 1'b1);
    settle();

    // A dimension of zero behaves as one.
    write_dims(4'd0);
    queue_sample(16'sh1234, 1'b1);
    settle();

    // Above the vector length it behaves as eight; the set ends mid-vector.
    write_dims(4'd15);
    queue_sample(16'shC001, 1'b0);
    queue_sample(16'sh3FFF, 1'b0);
    queue_sample(16'sh8000, 1'b1);
    settle();

    // Shrinking the dimension mid-vector restarts the vector at position 0.
    write_dims(4'd3);
    queue_sample(16'sh0ABC, 1'b0);
    queue_sample(16'shF543, 1'b0);
    settle();
    write_dims(4'd2);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh8001, 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      // The receiver cannot stall, so only the sender's idle share varies by phase.
      sender_idle_pct = (p % 4 == 1) ? 74 : (p % 4 == 3) ? 9 : 0;
      case ($urandom_range(5))
        0:       dv = 4'd0;
        1:       dv = 4'd1;
        2:       dv = 4'd8;
        3:       dv = 4'd15;
        4:       dv = DIMS_W'($urandom_range(15));
        default: dv = DIMS_W'($urandom_range(2, 8));
      endcase
      write_dims(dv);
      d_eff = active_dims(dv);
      n = 0;
      while (n < 8) begin
        nvec = $urandom_range(1, 3);
        for (v = 0; v < nvec; v++) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(1, d_eff) : d_eff;
          for (e = 0; e < len; e++) begin
            // Mostly whole sets; now and then a set runs on or ends early.
            queue_sample(pick_sample(),
                         ((v == nvec - 1) && (e == len - 1) && ($urandom_range(9) != 0))
                         || ($urandom_range(49) == 0));
            n++;
          end
        end
      end
      settle();
    end

    do @(posedge clk);
    while (sample_backlog.size() != 0 || start);
    waited = 0;
    while (gram_expected.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (gram_expected.size() != 0)
      flag_mismatch($sformatf("%0d matrix entries never arrived", gram_expected.size()));

    $display("Sent %0d samples, checked %0d matrix entries over %0d dimension writes,",
             samples_taken, entries_seen, dims_writes);
    $display("with field extremes, sets ended mid-vector and dimension changes.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(100_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
